/* hdl/dapw_pkg.sv */
package dapw_pkg;

  localparam int FRAME_BITS     = 32;
  localparam int LA_BITS        = 4;
  localparam int LB_BITS        = 2;
  localparam int MAX_AHEAD_DEF  = 12;
  localparam int MAX_BEHIND_DEF = 3;

  // Fixed window for forward playback
  localparam logic [LA_BITS-1:0] PLAY_AHEAD  = 4'd3;
  localparam logic [LB_BITS-1:0] PLAY_BEHIND = 2'd0;

  // Register map (index = paddr[3:2])
  localparam int ADDR_BITS = 4;
  localparam logic [1:0] REG_FRAME_COUNT = 2'd0;
  localparam logic [1:0] REG_LOOK_AHEAD  = 2'd1;
  localparam logic [1:0] REG_LOOK_BEHIND = 2'd2;

  localparam logic [LA_BITS-1:0] LOOK_AHEAD_RST  = 4'd3;
  localparam logic [LB_BITS-1:0] LOOK_BEHIND_RST = 2'd0;

  typedef enum logic [1:0] {
    REQ_SEEK  = 2'd0,
    REQ_PLAY  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AHEAD,
    ST_BEHIND,
    ST_FLUSH
  } seq_state_t;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [FRAME_BITS-1:0] frame_index;
    logic                  frame_valid;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] target_frame;
    logic                  last;
  } out_item_t;

  // Window launch from the front end to the sequencer
  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic                  backward;
    logic [LA_BITS-1:0]    ahead;
    logic [LB_BITS-1:0]    behind;
  } start_cmd_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] target;
    logic                  keep;
  } step_res_t;

endpackage

/* hdl/dapw_step_unit.sv */
module dapw_step_unit
  import dapw_pkg::*;
#(
  parameter int K_W = 5
) (
  input  logic [FRAME_BITS-1:0] frame,
  input  logic [K_W-1:0]        step,
  input  logic                  down,
  input  logic [FRAME_BITS-1:0] frame_count,
  output step_res_t             res
);

  logic [FRAME_BITS:0] step_ext;
  logic [FRAME_BITS:0] operand;
  logic [FRAME_BITS:0] sum;

  // One adder serves both directions: subtract as add of the complement.
  // The top bit is a borrow (target below zero) or a carry (past any count).
  assign step_ext = {{(FRAME_BITS+1-K_W){1'b0}}, step};
  assign operand  = down ? ~step_ext : step_ext;
  assign sum      = {1'b0, frame} + operand + {{FRAME_BITS{1'b0}}, down};

  assign res.target = sum[FRAME_BITS-1:0];
  assign res.keep   = !sum[FRAME_BITS] && (sum[FRAME_BITS-1:0] < frame_count);

endmodule

/* hdl/dapw_seq.sv */
module dapw_seq
  import dapw_pkg::*;
#(
  parameter int MAX_AHEAD  = MAX_AHEAD_DEF,
  parameter int MAX_BEHIND = MAX_BEHIND_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start_valid,
  input  start_cmd_t            start_cmd,
  input  logic [FRAME_BITS-1:0] frame_count,
  output logic                  idle,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  localparam int RAW_MAX = (1 << LA_BITS) - 1;
  localparam int KA      = (MAX_AHEAD > MAX_BEHIND) ? MAX_AHEAD : MAX_BEHIND;
  localparam int KMAX    = (KA > RAW_MAX) ? KA : RAW_MAX;
  localparam int K_W     = $clog2(KMAX + 1);

  seq_state_t            state_r, state_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic                  back_r, back_nxt;
  logic [K_W-1:0]        k_r, k_nxt;
  logic [K_W-1:0]        ahead_r, ahead_nxt;
  logic [K_W-1:0]        behind_r, behind_nxt;
  logic [FRAME_BITS-1:0] pend_r, pend_nxt;
  logic                  pend_v_r, pend_v_nxt;
  out_item_t             out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic           down;
  logic           out_free;
  logic           step_go;
  logic [K_W-1:0] lim;
  logic [K_W-1:0] la_ext;
  logic [K_W-1:0] lb_ext;
  step_res_t      res;

  assign down = (state_r == ST_BEHIND) ? !back_r : back_r;
  assign lim  = (state_r == ST_BEHIND) ? behind_r : ahead_r;

  dapw_step_unit #(
    .K_W(K_W)
  ) u_step (
    .frame      (frame_r),
    .step       (k_r),
    .down       (down),
    .frame_count(frame_count),
    .res        (res)
  );

  assign la_ext   = K_W'(start_cmd.ahead);
  assign lb_ext   = K_W'(start_cmd.behind);
  assign out_free = !out_valid_r || out_ready;
  // A kept target only stalls when the held one cannot move out
  assign step_go  = !res.keep || !pend_v_r || out_free;

  always_comb begin
    state_nxt     = state_r;
    frame_nxt     = frame_r;
    back_nxt      = back_r;
    k_nxt         = k_r;
    ahead_nxt     = ahead_r;
    behind_nxt    = behind_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (start_valid) begin
          frame_nxt  = start_cmd.frame;
          back_nxt   = start_cmd.backward;
          ahead_nxt  = (la_ext > K_W'(MAX_AHEAD)) ? K_W'(MAX_AHEAD) : la_ext;
          behind_nxt = (lb_ext > K_W'(MAX_BEHIND)) ? K_W'(MAX_BEHIND) : lb_ext;
          k_nxt      = K_W'(1);
          state_nxt  = ST_AHEAD;
        end
      end
      ST_AHEAD, ST_BEHIND: begin
        if (step_go) begin
          if (res.keep) begin
            if (pend_v_r) begin
              out_nxt       = '{target_frame: pend_r, last: 1'b0};
              out_valid_nxt = 1'b1;
            end
            pend_nxt   = res.target;
            pend_v_nxt = 1'b1;
          end
          if (k_r == lim) begin
            k_nxt = K_W'(1);
            if (state_r == ST_AHEAD && behind_r != '0) begin
              state_nxt = ST_BEHIND;
            end else begin
              state_nxt = ST_FLUSH;
            end
          end else begin
            k_nxt = k_r + K_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_nxt       = '{target_frame: pend_r, last: 1'b1};
          out_valid_nxt = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      ahead_r     <= '0;
      behind_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      ahead_r     <= ahead_nxt;
      behind_r    <= behind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    back_r  <= back_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_start_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_valid |-> state_r == ST_IDLE)
    else $error("window launched while sequencer busy");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_v_r)
    else $error("held target left behind at end of window");

  a_ahead_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_AHEAD |-> k_r != '0 && k_r <= ahead_r && ahead_r <= K_W'(MAX_AHEAD))
    else $error("ahead step out of range");

  a_behind_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BEHIND |-> k_r != '0 && k_r <= behind_r && behind_r <= K_W'(MAX_BEHIND))
    else $error("behind step out of range");

endmodule

/* hdl/direction_aware_prefetch_window.sv */
// Direction-aware prefetch window. Each request on the in_ channel either
// clears the direction tracker or names a frame; for a frame it returns the
// list of frames to prefetch on the out_ channel, one target per result, the
// final one marked with last. An exact seek sets the travel direction from
// its frame against the previous seek, then yields up to look_ahead targets
// that way and up to look_behind the other way; forward playback always
// uses forward, three ahead, none behind. Targets below zero or at or above
// frame_count are dropped, and an invalid frame, a zero frame_count or a zero
// look_ahead on a seek yields nothing. Timing: one request is handled at a
// time. A request with a window keeps the block busy while it tests A ahead
// then B behind candidates, A and B being look_ahead and look_behind after
// saturation. A single adder/comparator tests one candidate target per cycle
// but stalls while a finished target waits on a still-full output register.
// Requests without a window do not start the sequencer. The output register
// lets the last result wait while the next request is taken. Registers (APB,
// 4-byte spacing): 0x0 frame_count, 0x4 look_ahead, 0x8 look_behind; write
// them only while the block is idle.
module direction_aware_prefetch_window
  import dapw_pkg::*;
#(
  parameter int MAX_AHEAD  = MAX_AHEAD_DEF,
  parameter int MAX_BEHIND = MAX_BEHIND_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  // configuration port
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  // Configuration registers
  logic [FRAME_BITS-1:0] frame_count_r;
  logic [LA_BITS-1:0]    look_ahead_r;
  logic [LB_BITS-1:0]    look_behind_r;

  // Direction tracker
  logic [FRAME_BITS-1:0] prev_frame_r, prev_frame_nxt;
  logic                  prev_valid_r, prev_valid_nxt;
  logic                  backward_r, backward_nxt;

  logic       cfg_wr;
  logic [1:0] cfg_idx;
  logic       req_acc;
  logic       is_seek;
  logic       is_play;
  logic       emit_ok;
  logic       seq_idle;
  start_cmd_t start_cmd;

  // Configuration port: writes land in the access phase; reads are decoded
  // straight from the address.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      look_ahead_r  <= LOOK_AHEAD_RST;
      look_behind_r <= LOOK_BEHIND_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_COUNT: frame_count_r <= cfg_pwdata[FRAME_BITS-1:0];
        REG_LOOK_AHEAD:  look_ahead_r  <= cfg_pwdata[LA_BITS-1:0];
        REG_LOOK_BEHIND: look_behind_r <= cfg_pwdata[LB_BITS-1:0];
        default: begin
          // drop writes beyond the register map
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_COUNT: cfg_prdata = frame_count_r;
      REG_LOOK_AHEAD:  cfg_prdata = {{(32-LA_BITS){1'b0}}, look_ahead_r};
      REG_LOOK_BEHIND: cfg_prdata = {{(32-LB_BITS){1'b0}}, look_behind_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // Take a new request only when the sequencer has finished the last window.
  assign in_ready = seq_idle;
  assign req_acc  = in_valid && in_ready;
  assign is_seek  = (in_data.req_type == REQ_SEEK);
  assign is_play  = (in_data.req_type == REQ_PLAY);

  // Track direction on every exact seek, valid frame or not: flip only when
  // the frame actually moves relative to a known previous seek. Clear resets
  // the tracker to forward with no history; the unused type leaves it alone.
  always_comb begin
    prev_frame_nxt = prev_frame_r;
    prev_valid_nxt = prev_valid_r;
    backward_nxt   = backward_r;
    if (req_acc) begin
      if (is_seek) begin
        if (prev_valid_r && in_data.frame_index != prev_frame_r) begin
          backward_nxt = (in_data.frame_index < prev_frame_r);
        end
        prev_frame_nxt = in_data.frame_index;
        prev_valid_nxt = 1'b1;
      end else if (in_data.req_type == REQ_CLEAR) begin
        prev_frame_nxt = '0;
        prev_valid_nxt = 1'b0;
        backward_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_frame_r <= '0;
      prev_valid_r <= 1'b0;
      backward_r   <= 1'b0;
    end else begin
      prev_frame_r <= prev_frame_nxt;
      prev_valid_r <= prev_valid_nxt;
      backward_r   <= backward_nxt;
    end
  end

  // Launch a window only when it can hold something: valid frame, nonzero
  // frame count and a nonzero look-ahead (playback always has three).
  assign emit_ok = req_acc && in_data.frame_valid && (frame_count_r != '0) &&
                   ((is_seek && look_ahead_r != '0) || is_play);

  always_comb begin
    start_cmd.frame = in_data.frame_index;
    if (is_seek) begin
      start_cmd.backward = backward_nxt;
      start_cmd.ahead    = look_ahead_r;
      start_cmd.behind   = look_behind_r;
    end else begin
      start_cmd.backward = 1'b0;
      start_cmd.ahead    = PLAY_AHEAD;
      start_cmd.behind   = PLAY_BEHIND;
    end
  end

  dapw_seq #(
    .MAX_AHEAD (MAX_AHEAD),
    .MAX_BEHIND(MAX_BEHIND)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_valid(emit_ok),
    .start_cmd  (start_cmd),
    .frame_count(frame_count_r),
    .idle       (seq_idle),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
  import dapw_pkg::*;
;

  // Request type code that the block must ignore (not part of req_type_t)
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // Register index past the end of the map; writes to it must be dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Leave margin for a full 12 + 3 window to finish before touching
  // registers once the last expected target has gone out.
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 48;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  out_item_t            out_data;
  logic                 cfg_psel;
  logic                 cfg_penable;
  logic                 cfg_pwrite;
  logic [ADDR_BITS-1:0] cfg_paddr;
  logic [31:0]          cfg_pwdata;
  logic [31:0]          cfg_prdata;
  logic                 cfg_pready;

  // Shadow copy of the registers and of the direction tracker
  logic [31:0] frame_count_reg;
  logic [3:0]  look_ahead_reg;
  logic [1:0]  look_behind_reg;
  logic [31:0] seek_frame;
  logic        seek_seen;
  logic        seek_backward;

  // Targets predicted but not yet seen on the result channel, oldest first
  out_item_t pending_targets[$];
  out_item_t target_head;

  int fail_count  = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  int stall_mode  = 0;
  int stall_phase = 0;
  int stall_run   = 0;

  direction_aware_prefetch_window u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached, %0d targets outstanding", $time,
               pending_targets.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  // Receiver back-pressure: periodically pick a new mode at random - always
  // ready, random single-cycle stalls, or stall runs of random length.
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_mode  = $urandom_range(0, 2);
      stall_phase = 48;
    end
    stall_phase--;
    case (stall_mode)
      0: out_ready = 1'b1;
      1: out_ready = ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_run > 0) begin
          out_ready = 1'b0;
          stall_run--;
        end else begin
          out_ready = 1'b1;
          if ($urandom_range(0, 3) == 0) stall_run = $urandom_range(1, 8);
        end
      end
    endcase
  end

  // Compare every accepted target with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_targets.size() == 0) begin
        $display("%0t: unexpected target: expected none, got frame %h last %b", $time,
                 out_data.target_frame, out_data.last);
        fail_count++;
      end else begin
        target_head = pending_targets.pop_front();
        if (out_data.target_frame !== target_head.target_frame) begin
          $display("%0t: target_frame mismatch: expected %h, got %h", $time,
                   target_head.target_frame, out_data.target_frame);
          fail_count++;
        end
        if (out_data.last !== target_head.last) begin
          $display("%0t: last mismatch on frame %h: expected %b, got %b", $time,
                   target_head.target_frame, target_head.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  // Walk ahead targets then behind targets, drop those below zero or at or
  // beyond frame_count, mark the final survivor.
  function automatic void build_window(input logic [31:0] frame, input logic backward,
                                       input int ahead, input int behind);
    logic [63:0] base;
    logic [63:0] target;
    logic        down;
    int          span;
    out_item_t   hits[$];
    out_item_t   hit;
    base = {32'd0, frame};
    if (frame_count_reg == 32'd0 || ahead == 0) return;
    if (ahead > MAX_AHEAD_DEF) ahead = MAX_AHEAD_DEF;
    if (behind > MAX_BEHIND_DEF) behind = MAX_BEHIND_DEF;
    for (int pass = 0; pass < 2; pass++) begin
      span = (pass == 0) ? ahead : behind;
      down = (pass == 0) ? backward : !backward;
      for (int k = 1; k <= span; k++) begin
        if (down) begin
          if (base < 64'(k)) continue;
          target = base - 64'(k);
        end else begin
          target = base + 64'(k);
        end
        if (target < {32'd0, frame_count_reg}) begin
          hit.target_frame = target[31:0];
          hit.last         = 1'b0;
          hits = {hits, hit};
        end
      end
    end
    if (hits.size() > 0) hits[hits.size()-1].last = 1'b1;
    foreach (hits[i]) pending_targets = {pending_targets, hits[i]};
  endfunction

  // Advance the tracker for one accepted request and queue its targets
  function automatic void predict_window(input in_item_t req);
    case (req.req_type)
      REQ_SEEK: begin
        // invalid seeks still move the tracker
        if (seek_seen && req.frame_index != seek_frame)
          seek_backward = req.frame_index < seek_frame;
        seek_frame = req.frame_index;
        seek_seen  = 1'b1;
        if (req.frame_valid)
          build_window(req.frame_index, seek_backward, int'(look_ahead_reg),
                       int'(look_behind_reg));
      end
      REQ_PLAY: begin
        if (req.frame_valid)
          build_window(req.frame_index, 1'b0, int'(PLAY_AHEAD), int'(PLAY_BEHIND));
      end
      REQ_CLEAR: begin
        seek_seen     = 1'b0;
        seek_frame    = 32'd0;
        seek_backward = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t make_req(input logic [1:0] kind, input logic [31:0] frame,
                                        input logic ok);
    in_item_t req;
    req.req_type    = kind;
    req.frame_index = frame;
    req.frame_valid = ok;
    return req;
  endfunction

  // Present one request and hold it until accepted. Bursts of random length
  // are separated by random gaps; a zero gap keeps valid high.
  task automatic send_request(input in_item_t req);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    in_data  = req;
    in_valid = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_window(req);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted target is out and the block
  // has had time to finish any window whose targets were all dropped.
  task automatic settle();
    in_valid   = 1'b0;
    burst_left = 0;
    while (pending_targets.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready
  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic check_reg(input logic [1:0] idx);
    logic [31:0] rd;
    logic [31:0] want;
    case (idx)
      REG_FRAME_COUNT: want = frame_count_reg;
      REG_LOOK_AHEAD:  want = {28'd0, look_ahead_reg};
      default:         want = {30'd0, look_behind_reg};
    endcase
    apb_access(1'b0, idx, 32'd0, rd);
    if (rd !== want) begin
      $display("%0t: register %0d readback: expected %h, got %h", $time, idx, want, rd);
      fail_count++;
    end
  endtask

  // Write a register, mirror it in the shadow copy, read it back
  task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    apb_access(1'b1, idx, value, rd);
    case (idx)
      REG_FRAME_COUNT: frame_count_reg = value;
      REG_LOOK_AHEAD:  look_ahead_reg  = value[3:0];
      REG_LOOK_BEHIND: look_behind_reg = value[1:0];
      default: ;
    endcase
    if (idx != REG_UNUSED) check_reg(idx);
  endtask

  task automatic program_window(input logic [31:0] count, input logic [3:0] ahead,
                                input logic [1:0] behind);
    program_reg(REG_FRAME_COUNT, count);
    program_reg(REG_LOOK_AHEAD, {28'd0, ahead});
    program_reg(REG_LOOK_BEHIND, {30'd0, behind});
  endtask

  // Reset values, and a zero frame_count that must swallow every request
  task automatic check_reset_values();
    check_reg(REG_FRAME_COUNT);
    check_reg(REG_LOOK_AHEAD);
    check_reg(REG_LOOK_BEHIND);
    send_request(make_req(REQ_SEEK, 32'd5, 1'b1));
    send_request(make_req(REQ_PLAY, 32'd5, 1'b1));
    settle();
    program_reg(REG_FRAME_COUNT, 32'd64);
    // default window: three ahead, none behind, direction from the seek at 5
    send_request(make_req(REQ_SEEK, 32'd10, 1'b1));
    settle();
  endtask

  // Forward, backward, equal, invalid-but-tracked seeks, clear, ignored type
  task automatic check_direction_tracking();
    program_window(32'd64, 4'd4, 2'd2);
    send_request(make_req(REQ_CLEAR, 32'hFFFF_FFFF, 1'b1));
    send_request(make_req(REQ_SEEK, 32'd20, 1'b1));
    send_request(make_req(REQ_SEEK, 32'd10, 1'b1));
    send_request(make_req(REQ_SEEK, 32'd10, 1'b1));
    send_request(make_req(REQ_SEEK, 32'd30, 1'b0));
    send_request(make_req(REQ_SEEK, 32'd30, 1'b1));
    send_request(make_req(REQ_UNUSED, 32'd2, 1'b1));
    send_request(make_req(REQ_SEEK, 32'd25, 1'b1));
    send_request(make_req(REQ_CLEAR, 32'd0, 1'b0));
    send_request(make_req(REQ_SEEK, 32'd5, 1'b1));
    send_request(make_req(REQ_PLAY, 32'd60, 1'b1));
    send_request(make_req(REQ_PLAY, 32'd7, 1'b0));
    settle();
  endtask

  // Saturation, frames at zero and at the top of the range, zero look-ahead,
  // a one-frame media, and a write past the register map
  task automatic check_window_edges();
    program_window(32'hFFFF_FFFF, 4'd15, 2'd3);
    send_request(make_req(REQ_SEEK, 32'hFFFF_FFFE, 1'b1));
    send_request(make_req(REQ_SEEK, 32'd3, 1'b1));
    send_request(make_req(REQ_SEEK, 32'd0, 1'b1));
    send_request(make_req(REQ_SEEK, 32'hFFFF_FFFF, 1'b1));
    send_request(make_req(REQ_PLAY, 32'hFFFF_FFFD, 1'b1));
    settle();
    program_reg(REG_UNUSED, 32'hFFFF_FFFF);
    check_reg(REG_FRAME_COUNT);
    check_reg(REG_LOOK_AHEAD);
    check_reg(REG_LOOK_BEHIND);
    program_reg(REG_LOOK_AHEAD, 32'd0);
    send_request(make_req(REQ_SEEK, 32'd100, 1'b1));
    send_request(make_req(REQ_PLAY, 32'd100, 1'b1));
    settle();
    program_window(32'd1, 4'd12, 2'd3);
    send_request(make_req(REQ_SEEK, 32'd0, 1'b1));
    send_request(make_req(REQ_PLAY, 32'd0, 1'b1));
    settle();
  endtask

  // Mostly seeks that wander around a moving base so the direction tracker
  // flips often, mixed with playback, clears, invalid frames and noise.
  task automatic run_random_traffic();
    int          counted;
    int          pick;
    int          sel;
    logic [31:0] frame;
    logic [31:0] base;
    logic [1:0]  kind;
    logic        ok;
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase == 0) begin
        program_window($urandom_range(20, 200), 4'd12, 2'd3);
      end else if (phase == 1) begin
        program_window(32'hFFFF_FFFF, 4'd1, 2'd0);
      end else begin
        pick = $urandom_range(0, 9);
        program_window(pick < 7 ? $urandom_range(1, 400) : (pick < 8 ? 32'hFFFF_FFFF :
                       (pick < 9 ? $urandom() : 32'd0)),
                       ($urandom_range(0, 7) == 0) ? 4'd0 : 4'($urandom_range(1, 15)),
                       2'($urandom_range(0, 3)));
      end
      base    = (frame_count_reg == 0) ? $urandom() : $urandom() % frame_count_reg;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        // hold off now and then until the block has drained
        if (phase % 2 == 1 && counted == PHASE_ITEMS / 2) settle();
        pick = $urandom_range(0, 99);
        if (pick < 8) kind = REQ_CLEAR;
        else if (pick < 12) kind = REQ_UNUSED;
        else if (pick < 32) kind = REQ_PLAY;
        else kind = REQ_SEEK;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
          if ($urandom_range(0, 1) == 1) base = base + $urandom_range(0, 6);
          else base = base - $urandom_range(0, 6);
          frame = base;
        end else if (sel < 7) begin
          frame = $urandom_range(0, 4);
        end else if (sel < 8) begin
          frame = frame_count_reg - $urandom_range(0, 14);
        end else begin
          frame = $urandom();
        end
        ok = ($urandom_range(0, 9) != 0);
        send_request(make_req(kind, frame, ok));
        counted++;
      end
    end
    settle();
  endtask

  initial begin
    in_valid        = 1'b0;
    in_data         = '0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = 32'd0;
    frame_count_reg = 32'd0;
    look_ahead_reg  = LOOK_AHEAD_RST;
    look_behind_reg = LOOK_BEHIND_RST;
    seek_frame      = 32'd0;
    seek_seen       = 1'b0;
    seek_backward   = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    check_reset_values();
    check_direction_tracking();
    check_window_edges();
    run_random_traffic();

    settle();
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

/* direction_aware_prefetch_window.f */
hdl/dapw_pkg.sv
hdl/dapw_step_unit.sv
hdl/dapw_seq.sv
hdl/direction_aware_prefetch_window.sv
bench/tb_top.sv
